FILE: rtl/core/fcw_pkg.sv
// Shared types and constants for the FAT12 cluster chain walker.
package fcw_pkg;

    localparam int TABLE_BYTES = 8192;
    localparam int TBL_AW      = $clog2(TABLE_BYTES);
    localparam int OFF_W       = 13;

    localparam logic [11:0] CHAIN_END    = 12'hFF8;
    localparam logic [11:0] MIN_CLUSTER  = 12'd2;
    localparam logic [7:0]  LO_NIB_MASK  = 8'h0F;
    localparam logic [7:0]  HI_NIB_MASK  = 8'hF0;
    localparam logic [19:0] SECTOR_MAX   = 20'hFFFFF;

    localparam logic [15:0] DS_RESET     = 16'd0;
    localparam logic [7:0]  SPC_RESET    = 8'd1;
    localparam logic [11:0] LIMIT_RESET  = 12'd4084;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_DATA_START = 2'd0,
        REG_SPC        = 2'd1,
        REG_LIMIT      = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_NEXT  = 2'd2,
        OP_COUNT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_END     = 2'd1,
        ST_INVALID = 2'd2,
        ST_LONG    = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [12:0] byte_index;
        logic [7:0]  byte_value;
        logic [11:0] start_cluster;
    } t_in_word;

    typedef struct packed {
        logic [19:0] sector_address;
        logic [11:0] next_link;
        logic [11:0] chain_length;
        t_status     status;
    } t_out_word;

    typedef enum logic [1:0] {
        ALU_LINK = 2'd0,
        ALU_MUL  = 2'd1,
        ALU_ADD  = 2'd2
    } t_alu_fn;

    typedef struct packed {
        t_alu_fn     fn;
        logic [11:0] cluster;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  spc;
        logic [15:0] ds;
        logic [19:0] acc;
    } t_alu_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REP,
        S_CHK,
        S_RD0,
        S_RD1,
        S_RD2,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

endpackage

FILE: rtl/core/fcw_ram.sv
// Generic simple dual-port RAM with registered read.
module fcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/fcw_alu.sv
// Shared arithmetic unit: link unpack, sector multiply, saturating add.
module fcw_alu (
    input  fcw_pkg::t_alu_req i_req,
    output logic [19:0]       o_res
);

    logic [11:0] clus_m2;
    logic [20:0] sum;
    logic [11:0] link;

    assign clus_m2 = i_req.cluster - fcw_pkg::MIN_CLUSTER;
    assign sum     = {5'd0, i_req.ds} + {1'b0, i_req.acc};

    // even cluster: low nibble of the next byte on top; odd: high nibble of its byte below
    always_comb begin
        if (i_req.cluster[0] == 1'b0) begin
            link = {i_req.hi[3:0], i_req.lo};
        end else begin
            link = {i_req.hi, i_req.lo[7:4]};
        end
    end

    always_comb begin
        unique case (i_req.fn)
            fcw_pkg::ALU_LINK: o_res = {8'd0, link};
            fcw_pkg::ALU_MUL:  o_res = 20'(clus_m2) * 20'(i_req.spc);
            fcw_pkg::ALU_ADD: begin
                if (sum[20]) begin
                    o_res = fcw_pkg::SECTOR_MAX;
                end else begin
                    o_res = sum[19:0];
                end
            end
            default: o_res = '0;
        endcase
    end

endmodule

FILE: rtl/core/fat12_cluster_chain_walker_core.sv
// FAT12 chain walker top: config port, sequencer, table RAM and shared unit.
// Load goes straight to the result; start checks the cluster, then reads its link and
// computes the sector; advance checks the cursor, follows its link and reports as start
// does. Count follows the chain, each step set by two byte reads through the
// single table RAM read port. A result still held at the output stalls the sequencer.
// Throughput: one word at a time; the next word is taken once the sequencer is idle.
// Reset: synchronous active low; resets control, cursor (0xFF8) and config registers.
module fat12_cluster_chain_walker_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  fcw_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output fcw_pkg::t_out_word           o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    fcw_pkg::t_state    r_state, n_state;
    fcw_pkg::t_op       r_op, n_op;
    logic [11:0]        r_c, n_c;
    logic [11:0]        r_cursor, n_cursor;
    logic [11:0]        r_count, n_count;
    logic [7:0]         r_lo, n_lo;
    logic [19:0]        r_acc, n_acc;
    fcw_pkg::t_out_word r_res, n_res;
    logic               r_out_valid, n_out_valid;
    fcw_pkg::t_out_word r_out_word, n_out_word;

    logic [15:0] r_ds;
    logic [7:0]  r_spc;
    logic [11:0] r_limit;

    logic                        cfg_wr;
    logic                        in_acc;
    logic [fcw_pkg::OFF_W-1:0]   off;
    logic [fcw_pkg::OFF_W-1:0]   off1;
    logic                        off_oob;
    logic                        off1_oob;
    logic [fcw_pkg::OFF_W-1:0]   rd_off;
    logic                        ram_we;
    logic [7:0]                  ram_rdata;
    logic [7:0]                  rd_byte;
    fcw_pkg::t_alu_req           alu_req;
    logic [19:0]                 alu_res;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds    <= fcw_pkg::DS_RESET;
            r_spc   <= fcw_pkg::SPC_RESET;
            r_limit <= fcw_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[3:2] == fcw_pkg::REG_DATA_START) begin
                r_ds <= pwdata[15:0];
            end
            if (paddr[3:2] == fcw_pkg::REG_SPC) begin
                r_spc <= pwdata[7:0];
            end
            if (paddr[3:2] == fcw_pkg::REG_LIMIT) begin
                r_limit <= pwdata[11:0];
            end
        end
    end

    always_comb begin
        if (paddr[3:2] == fcw_pkg::REG_DATA_START) begin
            prdata = {16'd0, r_ds};
        end else if (paddr[3:2] == fcw_pkg::REG_SPC) begin
            prdata = {24'd0, r_spc};
        end else if (paddr[3:2] == fcw_pkg::REG_LIMIT) begin
            prdata = {20'd0, r_limit};
        end else begin
            prdata = '0;
        end
    end

    // table RAM
    assign off      = {1'b0, r_c} + {2'b00, r_c[11:1]};
    assign off1     = off + 13'd1;
    assign off_oob  = {1'b0, off}  >= 14'(fcw_pkg::TABLE_BYTES);
    assign off1_oob = {1'b0, off1} >= 14'(fcw_pkg::TABLE_BYTES);
    assign rd_off   = (r_state == fcw_pkg::S_RD1) ? off1 : off;

    assign in_acc = i_in_valid & o_in_ready;
    assign ram_we = in_acc & (i_in_word.op == fcw_pkg::OP_LOAD)
                  & ({1'b0, i_in_word.byte_index} < 14'(fcw_pkg::TABLE_BYTES));

    fcw_ram #(
        .WIDTH (8),
        .DEPTH (fcw_pkg::TABLE_BYTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_word.byte_index[fcw_pkg::TBL_AW-1:0]),
        .i_wdata (i_in_word.byte_value),
        .i_raddr (rd_off[fcw_pkg::TBL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // shared unit
    always_comb begin
        alu_req         = '0;
        alu_req.cluster = r_c;
        alu_req.lo      = r_lo;
        alu_req.hi      = rd_byte;
        alu_req.spc     = r_spc;
        alu_req.ds      = r_ds;
        alu_req.acc     = r_acc;
        unique case (r_state)
            fcw_pkg::S_MUL: alu_req.fn = fcw_pkg::ALU_MUL;
            fcw_pkg::S_ADD: alu_req.fn = fcw_pkg::ALU_ADD;
            default:        alu_req.fn = fcw_pkg::ALU_LINK;
        endcase
    end

    fcw_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // byte read in RD1 is the low byte, in RD2 the high byte
    always_comb begin
        if (r_state == fcw_pkg::S_RD1) begin
            rd_byte = off_oob ? 8'd0 : ram_rdata;
        end else begin
            rd_byte = off1_oob ? 8'd0 : ram_rdata;
        end
    end

    assign o_in_ready  = (r_state == fcw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcw_pkg::S_IDLE;
            r_cursor    <= fcw_pkg::CHAIN_END;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_c        <= n_c;
        r_count    <= n_count;
        r_lo       <= n_lo;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_c         = r_c;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_lo        = r_lo;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            fcw_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_op    = i_in_word.op;
                    n_count = '0;
                    unique case (i_in_word.op)
                        fcw_pkg::OP_LOAD: n_state = fcw_pkg::S_DONE;
                        fcw_pkg::OP_START: begin
                            n_c      = i_in_word.start_cluster;
                            n_cursor = i_in_word.start_cluster;
                            n_state  = fcw_pkg::S_REP;
                        end
                        fcw_pkg::OP_NEXT: begin
                            n_c = r_cursor;
                            if (r_cursor >= fcw_pkg::CHAIN_END) begin
                                n_res.status = fcw_pkg::ST_END;
                                n_state      = fcw_pkg::S_DONE;
                            end else if (r_cursor < fcw_pkg::MIN_CLUSTER) begin
                                n_res.status = fcw_pkg::ST_INVALID;
                                n_state      = fcw_pkg::S_DONE;
                            end else begin
                                n_state = fcw_pkg::S_RD0;
                            end
                        end
                        fcw_pkg::OP_COUNT: begin
                            n_c     = i_in_word.start_cluster;
                            n_state = fcw_pkg::S_CHK;
                        end
                        default: n_state = fcw_pkg::S_IDLE;
                    endcase
                end
            end
            fcw_pkg::S_REP: begin
                if (r_c >= fcw_pkg::CHAIN_END) begin
                    n_res.status = fcw_pkg::ST_END;
                    n_state      = fcw_pkg::S_DONE;
                end else if (r_c < fcw_pkg::MIN_CLUSTER) begin
                    n_res.status = fcw_pkg::ST_INVALID;
                    n_state      = fcw_pkg::S_DONE;
                end else begin
                    n_state = fcw_pkg::S_RD0;
                end
            end
            fcw_pkg::S_CHK: begin
                n_res.chain_length = r_count;
                if (r_c >= fcw_pkg::CHAIN_END) begin
                    n_res.status = fcw_pkg::ST_OK;
                    n_state      = fcw_pkg::S_DONE;
                end else if (r_c < fcw_pkg::MIN_CLUSTER) begin
                    n_res.status = fcw_pkg::ST_INVALID;
                    n_state      = fcw_pkg::S_DONE;
                end else if (r_count >= r_limit) begin
                    n_res.status = fcw_pkg::ST_LONG;
                    n_state      = fcw_pkg::S_DONE;
                end else begin
                    n_state = fcw_pkg::S_RD0;
                end
            end
            fcw_pkg::S_RD0: n_state = fcw_pkg::S_RD1;
            fcw_pkg::S_RD1: begin
                n_lo    = rd_byte;
                n_state = fcw_pkg::S_RD2;
            end
            fcw_pkg::S_RD2: begin
                unique case (r_op)
                    fcw_pkg::OP_COUNT: begin
                        n_c     = alu_res[11:0];
                        n_count = r_count + 12'd1;
                        n_state = fcw_pkg::S_CHK;
                    end
                    fcw_pkg::OP_NEXT: begin
                        // cursor follows the link, then the new cluster is reported
                        n_c      = alu_res[11:0];
                        n_cursor = alu_res[11:0];
                        n_op     = fcw_pkg::OP_START;
                        n_state  = fcw_pkg::S_REP;
                    end
                    default: begin
                        n_res.next_link = alu_res[11:0];
                        n_state         = fcw_pkg::S_MUL;
                    end
                endcase
            end
            fcw_pkg::S_MUL: begin
                n_acc   = alu_res;
                n_state = fcw_pkg::S_ADD;
            end
            fcw_pkg::S_ADD: begin
                n_res.sector_address = alu_res;
                n_res.status         = fcw_pkg::ST_OK;
                n_state              = fcw_pkg::S_DONE;
            end
            fcw_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = fcw_pkg::S_IDLE;
                end
            end
            default: n_state = fcw_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: dv/tb_fat12_cluster_chain_walker_core.sv
// Self-checking testbench for the FAT12 cluster chain walker core.
module tb_fat12_cluster_chain_walker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REGION       = 48;
    localparam int QUIET_LIMIT  = 60000;
    localparam int DRAIN_CYCLES = 24;

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    fcw_pkg::t_in_word           i_in_word   = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    fcw_pkg::t_out_word          o_out_word;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [fcw_pkg::PADDR_W-1:0] paddr       = '0;
    logic [31:0]                 pwdata      = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    fat12_cluster_chain_walker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // view 0 tracks the words queued for sending, view 1 the words the block took
    bit [7:0]    fat_mem   [2][fcw_pkg::TABLE_BYTES];
    bit          fat_known [2][fcw_pkg::TABLE_BYTES];
    logic [11:0] cursor    [2] = '{fcw_pkg::CHAIN_END, fcw_pkg::CHAIN_END};
    logic [15:0] ds_reg    [2] = '{fcw_pkg::DS_RESET, fcw_pkg::DS_RESET};
    logic [7:0]  spc_reg   [2] = '{fcw_pkg::SPC_RESET, fcw_pkg::SPC_RESET};
    logic [11:0] limit_reg [2] = '{fcw_pkg::LIMIT_RESET, fcw_pkg::LIMIT_RESET};
    bit          blind_read;

    fcw_pkg::t_in_word  words_to_send[$];
    fcw_pkg::t_out_word results_due[$];
    int        words_pushed = 0;
    int        words_taken  = 0;
    int        fault_count  = 0;
    int        quiet_cycles = 0;
    int        send_gap     = 0;
    int        take_gap     = 0;
    bit        word_sent    = 1'b0;
    bit        stall_mode   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] table_byte(int v, int off);
        if (!fat_known[v][off]) blind_read = 1'b1;
        return fat_mem[v][off];
    endfunction

    function automatic logic [11:0] link_at(int v, logic [11:0] c);
        int         off;
        logic [7:0] lo;
        logic [7:0] hi;
        off = int'(c) + int'(c >> 1);
        lo  = table_byte(v, off);
        hi  = table_byte(v, off + 1);
        if (!c[0]) return {hi[3:0], lo};
        return {hi, lo[7:4]};
    endfunction

    function automatic fcw_pkg::t_out_word cluster_report(int v, logic [11:0] c);
        fcw_pkg::t_out_word r;
        int unsigned        sec;
        r = '0;
        r.status = fcw_pkg::ST_OK;
        if (c >= fcw_pkg::CHAIN_END) begin
            r.status = fcw_pkg::ST_END;
        end else if (c < fcw_pkg::MIN_CLUSTER) begin
            r.status = fcw_pkg::ST_INVALID;
        end else begin
            sec = int'(ds_reg[v]) + int'(c - fcw_pkg::MIN_CLUSTER) * int'(spc_reg[v]);
            r.sector_address = (sec > fcw_pkg::SECTOR_MAX) ? fcw_pkg::SECTOR_MAX : sec[19:0];
            r.next_link = link_at(v, c);
        end
        return r;
    endfunction

    function automatic fcw_pkg::t_out_word walk_word(int v, fcw_pkg::t_in_word w);
        fcw_pkg::t_out_word r;
        logic [11:0]        c;
        logic [11:0]        steps;
        r = '0;
        r.status = fcw_pkg::ST_OK;
        case (w.op)
            fcw_pkg::OP_LOAD: begin
                fat_mem[v][w.byte_index]   = w.byte_value;
                fat_known[v][w.byte_index] = 1'b1;
            end
            fcw_pkg::OP_START: begin
                cursor[v] = w.start_cluster;
                r = cluster_report(v, cursor[v]);
            end
            fcw_pkg::OP_NEXT: begin
                if (cursor[v] >= fcw_pkg::CHAIN_END) begin
                    r.status = fcw_pkg::ST_END;
                end else if (cursor[v] < fcw_pkg::MIN_CLUSTER) begin
                    r.status = fcw_pkg::ST_INVALID;
                end else begin
                    cursor[v] = link_at(v, cursor[v]);
                    r = cluster_report(v, cursor[v]);
                end
            end
            fcw_pkg::OP_COUNT: begin
                c = w.start_cluster;
                steps = '0;
                while (c < fcw_pkg::CHAIN_END && r.status == fcw_pkg::ST_OK) begin
                    if (c < fcw_pkg::MIN_CLUSTER) begin
                        r.status = fcw_pkg::ST_INVALID;
                    end else if (steps >= limit_reg[v]) begin
                        r.status = fcw_pkg::ST_LONG;
                    end else begin
                        steps = steps + 12'd1;
                        c = link_at(v, c);
                    end
                end
                r.chain_length = steps;
            end
        endcase
        return r;
    endfunction

    // queue a word only if it never reads a table byte that was not loaded
    task automatic offer_word(fcw_pkg::t_in_word w, output bit took);
        logic [11:0]        keep;
        fcw_pkg::t_out_word scratch;
        keep = cursor[0];
        blind_read = 1'b0;
        scratch = walk_word(0, w);
        took = !blind_read;
        if (took) begin
            words_to_send.push_back(w);
            words_pushed++;
        end else begin
            cursor[0] = keep;
        end
    endtask

    function automatic fcw_pkg::t_in_word make_word(fcw_pkg::t_op op, logic [11:0] cl);
        fcw_pkg::t_in_word w;
        w.op            = op;
        w.byte_index    = 13'($urandom);
        w.byte_value    = 8'($urandom);
        w.start_cluster = cl;
        return w;
    endfunction

    task automatic offer_op(fcw_pkg::t_op op, logic [11:0] cl, output bit took);
        offer_word(make_word(op, cl), took);
    endtask

    task automatic offer_load(logic [12:0] idx, logic [7:0] val);
        fcw_pkg::t_in_word w;
        bit                took;
        w = make_word(fcw_pkg::OP_LOAD, 12'($urandom));
        w.byte_index = idx;
        w.byte_value = val;
        offer_word(w, took);
    endtask

    task automatic set_link(logic [11:0] c, logic [11:0] link);
        int         off;
        logic [7:0] b0;
        logic [7:0] b1;
        off = int'(c) + int'(c >> 1);
        if (!c[0]) begin
            b0 = link[7:0];
            b1 = (fat_mem[0][off + 1] & fcw_pkg::HI_NIB_MASK) | {4'h0, link[11:8]};
        end else begin
            b0 = (fat_mem[0][off] & fcw_pkg::LO_NIB_MASK) | {link[3:0], 4'h0};
            b1 = link[11:4];
        end
        offer_load(13'(off), b0);
        offer_load(13'(off + 1), b1);
    endtask

    function automatic logic [11:0] pick_link(logic [11:0] c);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return (int'(c) + 1 < REGION) ? c + 12'd1
                                          : 12'($urandom_range(fcw_pkg::CHAIN_END, 4095));
        if (pick < 65) return 12'($urandom_range(2, REGION - 1));
        if (pick < 80) return 12'($urandom_range(fcw_pkg::CHAIN_END, 4095));
        if (pick < 87) return 12'($urandom_range(0, 1));
        return 12'($urandom);
    endfunction

    function automatic logic [11:0] pick_cluster();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 12'($urandom_range(2, REGION - 1));
        if (pick < 85) return 12'($urandom_range(fcw_pkg::CHAIN_END, 4095));
        if (pick < 90) return 12'($urandom_range(0, 1));
        return 12'($urandom);
    endfunction

    task automatic random_phase(int n);
        int           got;
        int           pick;
        bit           took;
        fcw_pkg::t_op op;
        logic [11:0]  c;
        got = 0;
        while (got < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                c = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(2, 4095))
                                                : 12'($urandom_range(2, REGION - 1));
                set_link(c, pick_link(c));
                got += 2;
            end else if (pick < 30) begin
                offer_load(($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 3 * REGION / 2 + 1))
                                                       : 13'($urandom), 8'($urandom));
                got++;
            end else begin
                if (pick < 55) op = fcw_pkg::OP_START;
                else if (pick < 80) op = fcw_pkg::OP_NEXT;
                else op = fcw_pkg::OP_COUNT;
                offer_op(op, pick_cluster(), took);
                if (took) got++;
            end
        end
    endtask

    task automatic write_reg(fcw_pkg::t_reg_idx idx, logic [31:0] value);
        int v;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        for (v = 0; v < 2; v++) begin
            case (idx)
                fcw_pkg::REG_DATA_START: ds_reg[v]    = value[15:0];
                fcw_pkg::REG_SPC:        spc_reg[v]   = value[7:0];
                fcw_pkg::REG_LIMIT:      limit_reg[v] = value[11:0];
                default: ;
            endcase
        end
    endtask

    task automatic configure(logic [15:0] ds, logic [7:0] spc, logic [11:0] limit);
        write_reg(fcw_pkg::REG_DATA_START, 32'(ds));
        write_reg(fcw_pkg::REG_SPC, 32'(spc));
        write_reg(fcw_pkg::REG_LIMIT, 32'(limit));
    endtask

    task automatic drain();
        while (!(words_taken == words_pushed && results_due.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            fault_count++;
        end
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_sent)) begin
            word_sent = 1'b0;
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (words_to_send.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_word  <= words_to_send.pop_front();
                if (stall_mode && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        if (take_gap != 0) begin
            i_out_ready <= 1'b0;
            take_gap = take_gap - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (stall_mode && $urandom_range(0, 5) == 0) take_gap = $urandom_range(1, 13);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        fcw_pkg::t_out_word want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_out_valid && i_out_ready) begin
                quiet_cycles = 0;
                if (results_due.size() == 0) begin
                    $error("result word %h with nothing expected", o_out_word);
                    fault_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("sector_address", 32'(want.sector_address),
                                32'(o_out_word.sector_address));
                    check_field("next_link", 32'(want.next_link), 32'(o_out_word.next_link));
                    check_field("chain_length", 32'(want.chain_length),
                                32'(o_out_word.chain_length));
                    check_field("status", 32'(want.status), 32'(o_out_word.status));
                end
            end
            if (i_in_valid && o_in_ready) begin
                quiet_cycles = 0;
                results_due.push_back(walk_word(1, i_in_word));
                words_taken++;
                word_sent = 1'b1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("fat12_cluster_chain_walker_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        bit took;
        int k;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: cursor starts with no chain
        offer_op(fcw_pkg::OP_NEXT, 12'h000, took);
        offer_load(13'h1FFF, 8'hFF);
        offer_load(13'h0000, 8'h00);
        set_link(12'd2, 12'd3);
        set_link(12'd3, 12'd4);
        set_link(12'd4, 12'hFFF);
        set_link(12'd5, 12'd0);
        set_link(12'd6, 12'd6);
        offer_op(fcw_pkg::OP_START, 12'd2, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        offer_op(fcw_pkg::OP_START, 12'd0, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        offer_op(fcw_pkg::OP_START, 12'd1, took);
        offer_op(fcw_pkg::OP_START, 12'hFFF, took);
        offer_op(fcw_pkg::OP_START, 12'd5, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd2, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd5, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd6, took);
        offer_op(fcw_pkg::OP_COUNT, 12'hFF8, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd0, took);
        drain();

        configure(16'hFFFF, 8'd128, 12'd1);
        set_link(12'd4087, 12'hFFF);
        offer_op(fcw_pkg::OP_START, 12'd4087, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd4087, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd2, took);
        offer_op(fcw_pkg::OP_START, 12'd3, took);
        offer_op(fcw_pkg::OP_NEXT, 12'd0, took);
        drain();

        configure(16'h0000, 8'd1, 12'd4085);
        offer_op(fcw_pkg::OP_COUNT, 12'd6, took);
        offer_op(fcw_pkg::OP_COUNT, 12'd2, took);
        for (k = 2; k < REGION; k++) set_link(12'(k), pick_link(12'(k)));
        random_phase(40);
        drain();

        for (k = 0; k < 5; k++) begin
            configure(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 128)),
                      12'($urandom_range(1, 64)));
            stall_mode = (k != 4);
            random_phase((k == 4) ? 100 : 120);
            drain();
        end

        if (fault_count == 0) begin
            $display("fat12_cluster_chain_walker_core verification clean");
        end else begin
            $display("fat12_cluster_chain_walker_core verification failed");
        end
        $finish;
    end

endmodule
